// ===== rtl/gcsi_pkg.sv =====
package gcsi_pkg;

    localparam int CHAN_W          = 8;
    localparam int NUM_LANES       = 3;
    localparam int FRAC_BITS       = 24;
    localparam int ACC_W           = CHAN_W + FRAC_BITS;
    localparam int DIV_STEPS       = ACC_W;
    localparam int CNT_W           = $clog2(DIV_STEPS);
    localparam int SPAN_W          = 16;
    localparam int LENGTH_BITS_DEF = 16;

    // op codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] start_color;
        logic [31:0] end_color;
        logic [15:0] span_length;
    } gcsi_in_t;

    typedef struct packed {
        logic [31:0] color_out;
        logic        valid_res;
        logic        last;
    } gcsi_out_t;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } gcsi_state_t;

    // lane control from the sequencer
    typedef struct packed {
        logic load;
        logic iter;
        logic finish;
        logic advance;
        logic single;
    } gcsi_ctl_t;

endpackage

// ===== rtl/gcsi_lane.sv =====
module gcsi_lane #(
    parameter int LEN_W = gcsi_pkg::LENGTH_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gcsi_pkg::gcsi_ctl_t       ctl,
    input  logic [gcsi_pkg::CHAN_W-1:0] start_chan,
    input  logic [gcsi_pkg::CHAN_W-1:0] end_chan,
    input  logic [LEN_W-1:0]          divisor,
    output logic [gcsi_pkg::CHAN_W-1:0] chan_next
);
    import gcsi_pkg::*;

    logic [CHAN_W-1:0] a_reg;
    logic              neg_reg;
    logic [ACC_W-1:0]  dvd_reg;
    logic [ACC_W-1:0]  q_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [ACC_W-1:0]  step_reg;
    logic [ACC_W-1:0]  acc_reg;

    logic [CHAN_W-1:0] diff;
    logic [LEN_W:0]    rem_sh;
    logic              ge;
    logic [LEN_W:0]    rem_sub;
    logic [ACC_W-1:0]  q_new;
    logic [ACC_W-1:0]  acc_sum;

    assign diff    = (end_chan >= start_chan) ? (end_chan - start_chan)
                                              : (start_chan - end_chan);
    // one restoring quotient bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[ACC_W-1]};
    assign ge      = rem_sh >= {1'b0, divisor};
    assign rem_sub = rem_sh - {1'b0, divisor};
    assign q_new   = {q_reg[ACC_W-2:0], ge};
    assign acc_sum = acc_reg + step_reg;
    assign chan_next = acc_sum[ACC_W-1 -: CHAN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            acc_reg  <= '0;
        end
        else if (ctl.finish)
        begin
            if (ctl.single)
            begin
                step_reg <= '0;
                acc_reg  <= '0;
            end
            else
            begin
                step_reg <= neg_reg ? ~q_new : q_new;
                acc_reg  <= {a_reg, 1'b1, {(FRAC_BITS-1){1'b0}}};
            end
        end
        else if (ctl.advance)
        begin
            acc_reg <= acc_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg   <= start_chan;
            neg_reg <= end_chan < start_chan;
            dvd_reg <= {diff, {FRAC_BITS{1'b0}}};
            q_reg   <= '0;
            rem_reg <= '0;
        end
        else if (ctl.iter)
        begin
            dvd_reg <= {dvd_reg[ACC_W-2:0], 1'b0};
            q_reg   <= q_new;
            rem_reg <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
        end
    end

endmodule

// ===== rtl/gouraud_color_span_interpolator.sv =====
// Gouraud RGB span interpolator.
//
// Input channel req (req_valid / req_stall) carries one item: op, start
// and end colors, span length. A load item (op 0) latches a span and
// starts three per-channel serial dividers side by side (blue, green,
// red); it yields no result. The dividers produce one quotient bit per
// cycle, so after a load req_stall is high while the 8.24 steps
// settle. A next item (op 1) yields exactly one result on rsp
// (rsp_valid / rsp_stall) in the cycle after acceptance; while the
// block is idle and rsp is not stalled, next items are taken one per
// cycle. Each advance adds the step to each 32-bit accumulator and a
// merge stage packs the three channel bytes with the start alpha.
// A next item on an exhausted span returns color 0 with valid_res 0.
// The result sits in an output register; while rsp_stall holds it, a
// further item is not accepted (req_stall follows rsp_stall).
// Reset clears the span (remaining 0), the current color and the
// accumulators; the first next item after reset reports exhausted.
module gouraud_color_span_interpolator #(
    parameter int LENGTH_BITS = gcsi_pkg::LENGTH_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  gcsi_pkg::gcsi_in_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output gcsi_pkg::gcsi_out_t rsp
);
    import gcsi_pkg::*;

    // span_length is 16 bits wide; lengths wider than that cut nothing
    localparam int LEN_W = (LENGTH_BITS < SPAN_W) ? LENGTH_BITS : SPAN_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    gcsi_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  remaining_reg;
    logic [LEN_W-1:0]  divisor_reg;
    logic              single_reg;
    logic [31:0]       color_reg;
    logic              rsp_valid_reg;
    gcsi_out_t         rsp_reg;

    gcsi_ctl_t         ctl;
    logic              req_fire;
    logic              is_load;
    logic              is_next;
    logic [LEN_W-1:0]  len_raw;
    logic [LEN_W-1:0]  len_eff;
    logic [CHAN_W-1:0] chan_next [NUM_LANES];
    logic [31:0]       color_next;
    gcsi_out_t         result;

    assign req_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign req_fire  = req_valid && !req_stall;
    assign is_load   = req_fire && (req.op == OP_LOAD);
    assign is_next   = req_fire && (req.op == OP_NEXT);

    assign len_raw = req.span_length[LEN_W-1:0];
    assign len_eff = (len_raw == '0) ? LEN_W'(1) : len_raw;

    // sequencer: idle, or iterating the lane dividers
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ctl.load    = is_load;
        ctl.iter    = 1'b0;
        ctl.finish  = 1'b0;
        ctl.advance = is_next && (remaining_reg != '0);
        ctl.single  = single_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_load)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                ctl.iter = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // three channel lanes: blue, green, red
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        gcsi_lane #(
            .LEN_W (LEN_W)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .start_chan (req.start_color[i*CHAN_W +: CHAN_W]),
            .end_chan   (req.end_color[i*CHAN_W +: CHAN_W]),
            .divisor    (divisor_reg),
            .chan_next  (chan_next[i])
        );
    end

    // merge: pack lane bytes under the start alpha
    assign color_next = {color_reg[31:24], chan_next[2], chan_next[1], chan_next[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            color_reg     <= '0;
        end
        else if (is_load)
        begin
            remaining_reg <= len_eff;
            color_reg     <= req.start_color;
        end
        else if (ctl.advance)
        begin
            remaining_reg <= remaining_reg - LEN_W'(1);
            color_reg     <= color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            divisor_reg <= len_eff - LEN_W'(1);
            single_reg  <= (len_eff == LEN_W'(1));
        end
    end

    // result of a next item
    always_comb
    begin
        if (remaining_reg == '0)
        begin
            result.color_out = '0;
            result.valid_res = 1'b0;
            result.last      = 1'b0;
        end
        else
        begin
            result.color_out = color_reg;
            result.valid_res = 1'b1;
            result.last      = (remaining_reg == LEN_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (is_next)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_next)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== dv/gouraud_color_span_interpolator_test.sv =====
module gouraud_color_span_interpolator_test;
    import gcsi_pkg::*;

    // Length bits the block is built with; span_length is cut to these first.
    localparam int LEN_BITS     = LENGTH_BITS_DEF;
    // Cycles with no item moving on either side before the run is abandoned.
    // The longest legal quiet stretch is the receiver hold-off (HOLD_OFF)
    // with the input side backed up behind it, or a load's divide plus a gap.
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_OFF     = 300;
    localparam int HOLD_OFF_AT  = 200;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 40;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    gcsi_in_t  req;
    logic      rsp_valid;
    logic      rsp_stall;
    gcsi_out_t rsp;

    gouraud_color_span_interpolator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Span predictor: its own copy of the span state, reset values zero.
    // ------------------------------------------------------------------
    logic [16:0] span_left = '0;
    logic [31:0] lane_acc [3] = '{32'h0, 32'h0, 32'h0};
    logic [31:0] lane_step [3] = '{32'h0, 32'h0, 32'h0};
    logic [31:0] color_now = '0;

    gcsi_out_t   expected_colors [$];
    int          mismatches = 0;
    int          items_sent = 0;

    // Returns 1 when the item yields a result (every next item), 0 for a load.
    function automatic bit predict_span_color(input gcsi_in_t it, output gcsi_out_t res);
        int unsigned n;
        int          i;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [63:0] q;
        logic [31:0] nxt;
        res = '0;
        if (it.op == OP_LOAD)
        begin
            n = 32'(it.span_length) & ((32'd1 << LEN_BITS) - 32'd1);
            if (n == 0)
                n = 1;
            span_left = 17'(n);
            color_now = it.start_color;
            for (i = 0; i < 3; i++)
            begin
                a = it.start_color[8*i +: 8];
                b = it.end_color[8*i +: 8];
                if (n == 1)
                begin
                    // single color: lanes cleared, start color emitted as is
                    lane_step[i] = '0;
                    lane_acc[i]  = '0;
                end
                else
                begin
                    if (b >= a)
                    begin
                        q = (64'(b - a) << FRAC_BITS) / 64'(n - 1);
                        lane_step[i] = q[31:0];
                    end
                    else
                    begin
                        // falling lane keeps the one's complement of the step
                        q = (64'(a - b) << FRAC_BITS) / 64'(n - 1);
                        lane_step[i] = ~q[31:0];
                    end
                    // start value plus one half
                    lane_acc[i] = {a, 24'h80_0000};
                end
            end
            return 1'b0;
        end
        if (span_left == 0)
            return 1'b1;    // exhausted: all-zero result, no state change
        res.color_out = color_now;
        res.valid_res = 1'b1;
        res.last      = (span_left == 1);
        nxt = {color_now[31:24], 24'h0};
        for (i = 0; i < 3; i++)
        begin
            lane_acc[i] = lane_acc[i] + lane_step[i];   // wraps mod 2^32
            nxt[8*i +: 8] = lane_acc[i][31:24];
        end
        color_now = nxt;
        span_left = span_left - 1'b1;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Draws a random gap before each item, except in calm stretches
    // where items go back to back. valid stays high across back-to-back items
    // so it only ever gets one nonblocking write per time step.
    // ------------------------------------------------------------------
    task automatic offer_item(input gcsi_in_t it, input bit typed, input gcsi_out_t want);
        int        gap;
        bit        has_res;
        gcsi_out_t pred;
        gap = ((items_sent % 100) >= 80) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        // Predictor always runs so its state tracks the block; hand-typed
        // rows replace its output with the value written in the table.
        has_res = predict_span_color(it, pred);
        if (has_res)
            expected_colors.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // Directed items. Expected results are typed in where they follow at a
    // glance: after reset, one-color spans, two-color full-scale ramps up and
    // down (the falling one wraps the accumulators), and the exhausted span.
    // ------------------------------------------------------------------
    typedef struct {
        gcsi_in_t  item;
        bit        typed;
        gcsi_out_t want;
    } plan_row_t;

    plan_row_t directed_plan [0:25] = '{
        // next right after reset: span is empty
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1, '{32'h0, 1'b0, 1'b0}},
        // zero length counts as one color
        '{'{OP_LOAD, 32'hFF00_FF00, 32'h00FF_00FF, 16'h0000}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1,
          '{32'hFF00_FF00, 1'b1, 1'b1}},
        // past the end, with all-ones junk in the ignored fields
        '{'{OP_NEXT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{32'h0, 1'b0, 1'b0}},
        // full-scale rise over two colors
        '{'{OP_LOAD, 32'h1200_0000, 32'h00FF_FFFF, 16'h0002}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1,
          '{32'h1200_0000, 1'b1, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1,
          '{32'h12FF_FFFF, 1'b1, 1'b1}},
        // full-scale fall over two colors; accumulators wrap
        '{'{OP_LOAD, 32'hAAFF_FFFF, 32'h0000_0000, 16'h0002}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1,
          '{32'hAAFF_FFFF, 1'b1, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1,
          '{32'hAA00_0000, 1'b1, 1'b1}},
        // one color: end color has no say
        '{'{OP_LOAD, 32'h5A3C_7E01, 32'hFF10_C4E9, 16'h0001}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1,
          '{32'h5A3C_7E01, 1'b1, 1'b1}},
        // mixed rising and falling lanes with an uneven divide
        '{'{OP_LOAD, 32'h8040_2010, 32'h1020_4080, 16'h0007}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        // longest span, abandoned part way by a new load
        '{'{OP_LOAD, 32'h00FF_00FF, 32'hFF00_FF00, 16'hFFFF}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_LOAD, 32'h0102_0304, 32'h0506_0708, 16'h0003}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_NEXT, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '{32'h0, 1'b0, 1'b0}}
    };

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random spans, drain, verdict.
    // ------------------------------------------------------------------
    initial
    begin
        gcsi_in_t    item;
        int unsigned pick;
        int unsigned eff_len;
        int unsigned nexts;
        req_valid <= 1'b0;
        req       <= '0;
        rst_n     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[r])
            offer_item(directed_plan[r].item, directed_plan[r].typed, directed_plan[r].want);

        // Random part: mostly whole spans (load, then its colors, sometimes
        // running past the end or cut short by the next load), some noise.
        while (items_sent < RANDOM_ITEMS + 26)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                item.op          = OP_LOAD;
                item.start_color = $urandom;
                item.end_color   = $urandom;
                if ($urandom_range(0, 9) == 0)
                    item.end_color = item.start_color;   // flat span, zero steps
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    item.span_length = 16'($urandom_range(0, 8));
                else if (pick < 90)
                    item.span_length = 16'($urandom_range(9, 40));
                else
                    item.span_length = 16'($urandom_range(0, 65535));
                offer_item(item, 1'b0, '0);
                eff_len = (item.span_length == 0) ? 1 : item.span_length;
                nexts   = (eff_len > 40) ? $urandom_range(1, 40) : eff_len;
                pick    = $urandom_range(0, 9);
                if (pick == 0)
                    nexts = nexts + $urandom_range(1, 2);    // overrun
                else if (pick == 1 && nexts > 1)
                    nexts = $urandom_range(1, nexts - 1);    // cut short
                repeat (nexts)
                begin
                    item.op          = OP_NEXT;
                    item.start_color = $urandom;
                    item.end_color   = $urandom;
                    item.span_length = 16'($urandom);
                    offer_item(item, 1'b0, '0);
                end
            end
            else
            begin
                item.op          = $urandom_range(0, 1) ? OP_NEXT : OP_LOAD;
                item.start_color = $urandom;
                item.end_color   = $urandom;
                item.span_length = 16'($urandom);
                offer_item(item, 1'b0, '0);
            end
        end
        req_valid <= 1'b0;

        // drain; the watchdog catches a result that never comes
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("gouraud_color_span_interpolator_test passed");
        else
            $display("gouraud_color_span_interpolator_test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: checks each accepted result against the oldest expectation.
    // After each result it draws a random stall, with calm stretches of none.
    // Once, it holds off for the HOLD_OFF span so the block backs up and
    // stalls the input side.
    // ------------------------------------------------------------------
    initial
    begin
        gcsi_out_t want;
        int        hold;
        int        seen;
        bit        held_off;
        hold      = 0;
        seen      = 0;
        held_off  = 1'b0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("result with nothing expected: color_out %h valid_res %b last %b",
                           rsp.color_out, rsp.valid_res, rsp.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (rsp.color_out !== want.color_out)
                    begin
                        $error("color_out: expected %h, got %h", want.color_out, rsp.color_out);
                        mismatches++;
                    end
                    if (rsp.valid_res !== want.valid_res)
                    begin
                        $error("valid_res: expected %b, got %b", want.valid_res, rsp.valid_res);
                        mismatches++;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, rsp.last);
                        mismatches++;
                    end
                end
                seen++;
                hold = ((seen % 128) >= 96) ? 0 : $urandom_range(0, 11);
            end
            if (!held_off && seen == HOLD_OFF_AT)
            begin
                held_off  = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF) @(posedge clk);
                hold = 0;
            end
            else if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                hold--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Watchdog: counts cycles with no item moving on either side.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((req_valid === 1'b1 && req_stall === 1'b0) ||
            (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("gouraud_color_span_interpolator_test failed");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/gcsi_pkg.sv
rtl/gcsi_lane.sv
rtl/gouraud_color_span_interpolator.sv
dv/gouraud_color_span_interpolator_test.sv
